@@ rtl/bal_pkg.sv @@
package bal_pkg;

    localparam int BLOCK_LEN = 16;

    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 20;
    localparam int FS_W      = 12;
    localparam int LEVEL_W   = 7;
    localparam int NUM_W     = 19;

    localparam int CNT_W     = $clog2(BLOCK_LEN + 1);
    localparam int BIT_CNT_W = $clog2(SUM_W + 1);
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [FS_W-1:0]    FS_RESET   = FS_W'(1240);
    localparam logic [NUM_W-1:0]   PCT_SCALE  = NUM_W'(100);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = LEVEL_W'(100);

    typedef struct packed {
        logic                block_done;
        logic [SAMPLE_W-1:0] mean;
        logic [SAMPLE_W-1:0] baseline;
    } acc_stat_t;

endpackage

@@ rtl/bal_in_if.sv @@
interface bal_in_if
    import bal_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ rtl/bal_out_if.sv @@
interface bal_out_if
    import bal_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level_pct;
    logic               block_done;

    modport source (output valid, output level_pct, output block_done, input ready);
    modport sink   (input valid, input level_pct, input block_done, output ready);
endinterface

@@ rtl/block_average_level_percent_top.sv @@
// Block-average level meter. Each sample transfer is added into a 20-bit
// running sum; every 16 samples the rounded block mean is formed and the sum
// cleared, and the first block mean after reset becomes the baseline. Every
// sample yields one result: level_pct = 100*(baseline - mean)/full_scale_counts,
// truncated and clamped to 0..100 (0 while the mean is at or above baseline;
// 100 on any drop when full_scale_counts is 0), with block_done marking the
// sample that closed a block. A sample's result is formed by the bit-serial
// accumulator, which walks the 20-bit sum one bit per cycle. When a block
// completes, or on the first sample after a write to full_scale_counts, the
// bit-serial restoring divider also runs, one quotient bit per cycle over 19
// bits. One sample is processed at a time: a sample is taken only once the
// previous one's result is in the output register, and the next is taken while
// a finished result still waits there.
module block_average_level_percent_top
    import bal_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [FS_W-1:0]  cfg_wr_data,
    bal_in_if.sink           samples,
    bal_out_if.source        levels
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t             state_reg;
    logic [FS_W-1:0]    fs_reg;
    logic               dirty_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic               out_done_reg;

    acc_stat_t          stat;
    logic               acc_start;
    logic               acc_done;
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;
    logic               above;
    logic [SAMPLE_W-1:0] diff;
    logic [NUM_W-1:0]   num_calc;
    logic [LEVEL_W-1:0] level_next;
    logic               out_free;

    assign acc_start = samples.valid && samples.ready;
    assign above     = stat.baseline > stat.mean;
    assign diff      = above ? (stat.baseline - stat.mean) : '0;
    assign num_calc  = NUM_W'(diff) * PCT_SCALE;
    assign div_start = (state_reg == ST_ACC) && acc_done && (stat.block_done || dirty_reg);

    always_comb
    begin
        if (!above)
            level_next = '0;
        else if (div_quot >= NUM_W'(LEVEL_MAX))
            level_next = LEVEL_MAX;
        else
            level_next = div_quot[LEVEL_W-1:0];
    end

    assign out_free = !out_valid_reg || levels.ready;

    bal_acc u_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (acc_start),
        .sample (samples.sample),
        .done   (acc_done),
        .stat   (stat)
    );

    bal_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_calc),
        .den   (fs_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fs_reg        <= FS_RESET;
            dirty_reg     <= 1'b0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_level_reg <= '0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            if (levels.ready && (state_reg != ST_OUT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (acc_start)
                        state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (acc_done)
                    begin
                        if (div_start)
                        begin
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        level_reg <= level_next;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_level_reg <= level_reg;
                        out_done_reg  <= stat.block_done;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (cfg_wr_en)
            begin
                fs_reg    <= cfg_wr_data;
                dirty_reg <= 1'b1;
            end
            else if (div_start)
            begin
                dirty_reg <= 1'b0;
            end
        end
    end

    assign samples.ready     = (state_reg == ST_IDLE);
    assign levels.valid      = out_valid_reg;
    assign levels.level_pct  = out_level_reg;
    assign levels.block_done = out_done_reg;

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        levels.valid |-> (levels.level_pct <= LEVEL_MAX))
        else $error("level_pct above full scale");

    a_acc_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        acc_done |-> (state_reg == ST_ACC))
        else $error("accumulator finished outside accumulate phase");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide phase");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !samples.ready)
        else $error("second sample taken while one is in flight");

endmodule

@@ rtl/bal_acc.sv @@
module bal_acc
    import bal_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                done,
    output acc_stat_t           stat
);

    logic                 busy_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [SUM_W-1:0]     acc_reg;
    logic [SAMPLE_W-1:0]  add_reg;
    logic                 carry_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [SAMPLE_W-1:0]  mean_reg;
    logic [SAMPLE_W-1:0]  base_reg;
    logic                 base_valid_reg;
    logic                 done_reg;
    logic                 blk_reg;

    logic                 sum_bit;
    logic                 carry_next;
    logic [SUM_W:0]       acc_rnd;
    logic [SUM_W:0]       acc_quot;
    logic [SAMPLE_W-1:0]  mean_next;

    assign sum_bit    = acc_reg[0] ^ add_reg[0] ^ carry_reg;
    assign carry_next = (acc_reg[0] & add_reg[0]) | (acc_reg[0] & carry_reg)
                      | (add_reg[0] & carry_reg);

    assign acc_rnd   = {1'b0, acc_reg} + (SUM_W + 1)'(BLOCK_LEN / 2);
    assign acc_quot  = acc_rnd / (SUM_W + 1)'(BLOCK_LEN);
    assign mean_next = acc_quot[SAMPLE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            bit_cnt_reg    <= '0;
            acc_reg        <= '0;
            add_reg        <= '0;
            carry_reg      <= 1'b0;
            count_reg      <= '0;
            mean_reg       <= '0;
            base_reg       <= '0;
            base_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            blk_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg    <= 1'b1;
                bit_cnt_reg <= '0;
                add_reg     <= sample;
                carry_reg   <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (bit_cnt_reg != BIT_CNT_W'(SUM_W))
                begin
                    // rotate the sum one bit per cycle
                    acc_reg     <= {sum_bit, acc_reg[SUM_W-1:1]};
                    add_reg     <= {1'b0, add_reg[SAMPLE_W-1:1]};
                    carry_reg   <= carry_next;
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    if (count_reg == CNT_W'(BLOCK_LEN - 1))
                    begin
                        mean_reg  <= mean_next;
                        acc_reg   <= '0;
                        count_reg <= '0;
                        blk_reg   <= 1'b1;
                        if (!base_valid_reg)
                        begin
                            base_reg       <= mean_next;
                            base_valid_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        blk_reg   <= 1'b0;
                    end
                end
            end
        end
    end

    assign done            = done_reg;
    assign stat.block_done = blk_reg;
    assign stat.mean       = mean_reg;
    assign stat.baseline   = base_reg;

endmodule

@@ rtl/bal_div.sv @@
module bal_div
    import bal_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [FS_W-1:0]  den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [FS_W-1:0]      rem_reg;
    logic [FS_W-1:0]      den_reg;
    logic                 done_reg;

    logic [FS_W:0]        rem_sh;
    logic [FS_W:0]        rem_sub;
    logic                 ge;

    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= num;
                rem_reg  <= '0;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                // shift quotient bits in behind the numerator
                num_reg <= {num_reg[NUM_W-2:0], ge};
                rem_reg <= ge ? rem_sub[FS_W-1:0] : rem_sh[FS_W-1:0];
                if (cnt_reg == DIV_CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import bal_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 200;
    localparam int PHASES        = 8;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;

    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic               done;
    } level_rec_t;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        int                  reps;
        logic [LEVEL_W-1:0]  level;
        logic                done;
    } dir_row_t;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_wr_en;
    logic [FS_W-1:0] cfg_wr_data;

    bal_in_if  smp_ch ();
    bal_out_if lvl_ch ();

    block_average_level_percent_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (smp_ch),
        .levels      (lvl_ch)
    );

    always #4 clk = ~clk;

    // meter state mirrored from the accepted sample stream
    logic [FS_W-1:0]     fs_model;
    logic [SUM_W-1:0]    sum_model;
    int                  cnt_model;
    logic [SAMPLE_W-1:0] mean_model;
    logic [SAMPLE_W-1:0] base_model;
    logic                base_seen;

    level_rec_t pending_levels [$];
    level_rec_t head_rec;

    int errors       = 0;
    int sent         = 0;
    int n_results    = 0;
    int n_blocks     = 0;
    int n_full       = 0;
    int n_settings   = 1;
    int quiet_cycles = 0;
    int burst_left   = 0;
    bit gaps_on      = 1'b1;
    bit rdy_free     = 1'b0;
    logic [15:0] rdy_pattern = 16'hFFFF;
    int rdy_idx      = 0;

    dir_row_t dir_rows [8] = '{
        '{12'h000,  1, 7'd0,   1'b0},
        '{12'hFFF,  1, 7'd0,   1'b0},
        '{12'hAAA,  1, 7'd0,   1'b0},
        '{12'h555,  1, 7'd0,   1'b0},
        '{12'hFFF, 12, 7'd0,   1'b1},
        '{12'h000, 15, 7'd0,   1'b0},
        '{12'h000,  1, 7'd100, 1'b1},
        '{12'h800,  1, 7'd100, 1'b0}
    };

    function automatic logic [LEVEL_W-1:0] percent_drop();
        int diff;
        int q;
        if (base_model <= mean_model)
            return '0;
        diff = int'(base_model) - int'(mean_model);
        if (fs_model == '0)
            return LEVEL_MAX;
        q = (int'(PCT_SCALE) * diff) / int'(fs_model);
        return (q > int'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(q);
    endfunction

    function automatic level_rec_t absorb_sample(input logic [SAMPLE_W-1:0] s);
        level_rec_t r;
        sum_model = sum_model + SUM_W'(s);
        cnt_model = cnt_model + 1;
        r.done = 1'b0;
        if (cnt_model >= BLOCK_LEN) begin
            mean_model = SAMPLE_W'((int'(sum_model) + BLOCK_LEN / 2) / BLOCK_LEN);
            sum_model  = '0;
            cnt_model  = 0;
            r.done     = 1'b1;
            if (!base_seen) begin
                base_model = mean_model;
                base_seen  = 1'b1;
            end
        end
        r.level = percent_drop();
        return r;
    endfunction

    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else begin
            if (gaps_on) begin
                smp_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(negedge clk);
            end
            burst_left = $urandom_range(0, 24);
        end
    endtask

    task automatic push_sample(input logic [SAMPLE_W-1:0] s, input bit use_fixed,
                               input level_rec_t fixed_rec);
        level_rec_t r;
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= s;
        do @(posedge clk); while (!smp_ch.ready);
        r = absorb_sample(s);
        pending_levels.push_back(use_fixed ? fixed_rec : r);
        sent++;
        @(negedge clk);
        pace_sender();
    endtask

    task automatic drain_levels();
        smp_ch.valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_full_scale(input logic [FS_W-1:0] v);
        drain_levels();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        fs_model = v;
        n_settings++;
    endtask

    // hold ready on a rotating random pattern unless stall-free
    always @(negedge clk) begin
        if (rdy_free)
            lvl_ch.ready <= 1'b1;
        else begin
            if (rdy_idx == 0) begin
                rdy_pattern = $urandom_range(0, 1) ? 16'($urandom | $urandom)
                                                   : 16'($urandom & $urandom);
                rdy_pattern[$urandom_range(0, 15)] = 1'b1;
            end
            lvl_ch.ready <= rdy_pattern[rdy_idx];
            rdy_idx = (rdy_idx + 1) % 16;
        end
    end

    always @(posedge clk) begin
        if (rst_n && lvl_ch.valid && lvl_ch.ready) begin
            if (pending_levels.size() == 0) begin
                errors++;
                $display("%0t: unexpected result level_pct=%0d block_done=%0b",
                         $time, lvl_ch.level_pct, lvl_ch.block_done);
            end
            else begin
                head_rec = pending_levels.pop_front();
                n_results++;
                if (head_rec.done)
                    n_blocks++;
                if (head_rec.level == LEVEL_MAX)
                    n_full++;
                if (lvl_ch.level_pct !== head_rec.level) begin
                    errors++;
                    $display("%0t: level_pct mismatch expected %0d actual %0d",
                             $time, head_rec.level, lvl_ch.level_pct);
                end
                if (lvl_ch.block_done !== head_rec.done) begin
                    errors++;
                    $display("%0t: block_done mismatch expected %0b actual %0b",
                             $time, head_rec.done, lvl_ch.block_done);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (smp_ch.valid && smp_ch.ready) || (lvl_ch.valid && lvl_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int ph;
        int k;
        int r;
        int target;
        int amp;
        int span;
        int s;
        bit wild_block;
        level_rec_t fixed_rec;
        logic [FS_W-1:0] fs_plan [PHASES];

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        smp_ch.valid  = 1'b0;
        smp_ch.sample = '0;
        lvl_ch.ready  = 1'b0;
        fs_model      = FS_RESET;
        sum_model     = '0;
        cnt_model     = 0;
        mean_model    = '0;
        base_model    = '0;
        base_seen     = 1'b0;
        target        = 0;
        amp           = 0;
        wild_block    = 1'b0;

        fs_plan = '{12'd0, 12'd1, 12'hFFF, 12'd1240, 12'd37, 12'd2048, 12'd0, 12'd0};
        fs_plan[6] = FS_W'($urandom_range(1, SAMPLE_MAX));
        fs_plan[7] = FS_W'($urandom_range(1, 400));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset state, bit extremes, baseline latch, then a clamped full drop
        for (r = 0; r < 8; r++) begin
            for (k = 0; k < dir_rows[r].reps; k++) begin
                fixed_rec.level = dir_rows[r].level;
                fixed_rec.done  = dir_rows[r].done && (k == dir_rows[r].reps - 1);
                push_sample(dir_rows[r].sample, 1'b1, fixed_rec);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            set_full_scale(fs_plan[ph]);
            gaps_on  = (ph % 3 != 1);
            rdy_free = (ph % 3 == 1);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (cnt_model == 0) begin
                    wild_block = 1'b0;
                    case ($urandom_range(0, 7))
                        0: target = $urandom_range(base_model, SAMPLE_MAX);
                        1: wild_block = 1'b1;
                        default: begin
                            span = (fs_model == '0) ? 64 : int'(fs_model) * 11 / 10 + 2;
                            if (span > int'(base_model))
                                span = base_model;
                            target = int'(base_model) - int'($urandom_range(0, span));
                        end
                    endcase
                    amp = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 64);
                end
                if (wild_block || $urandom_range(0, 15) == 0)
                    s = $urandom_range(0, SAMPLE_MAX);
                else begin
                    s = target + int'($urandom_range(0, 2 * amp)) - amp;
                    if (s < 0)
                        s = 0;
                    if (s > SAMPLE_MAX)
                        s = SAMPLE_MAX;
                end
                push_sample(SAMPLE_W'(s), 1'b0, fixed_rec);
            end
        end

        drain_levels();
        $display("Sent %0d samples under %0d full-scale settings; checked %0d results,",
                 sent, n_settings, n_results);
        $display("%0d of them closing a block and %0d at the top of the scale.",
                 n_blocks, n_full);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
